// ===== src/overwriting_trace_log_buffer_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Trace log buffer assertion macros
// Clocked property checks shared by the trace buffer RTL.
// ---------------------------------------------------------------------------
`ifndef OVERWRITING_TRACE_LOG_BUFFER_UNIT_MACROS_SVH
`define OVERWRITING_TRACE_LOG_BUFFER_UNIT_MACROS_SVH

// Checked outside reset only.
`define OTLB_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("otlb assertion failed");

// Checked on every edge, reset included.
`define OTLB_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("otlb assertion failed");

`endif

// ===== src/otlb_pkg.sv =====
// ---------------------------------------------------------------------------
// Trace log buffer package
// Sizes, field widths and opcode/kind codes of the trace buffer.
// ---------------------------------------------------------------------------
package otlb_pkg;

  localparam int unsigned EntryDepth = 4096;
  localparam int unsigned PtrW       = $clog2(EntryDepth);
  localparam int unsigned CntW       = PtrW + 1;

  localparam int unsigned TimeW      = 32;
  localparam int unsigned BlockW     = 31;
  localparam int unsigned CountW     = 16;
  localparam int unsigned UnreadOutW = 13;
  localparam int unsigned EntryW     = 1 + BlockW + CountW + TimeW;

  localparam logic [PtrW-1:0] LastSlot  = PtrW'(EntryDepth - 1);
  localparam logic [CntW-1:0] FullCount = CntW'(EntryDepth);

  localparam logic OpRecord = 1'b0;
  localparam logic OpPop    = 1'b1;

  localparam logic [7:0] KindRead  = 8'd0;
  localparam logic [7:0] KindWrite = 8'd1;

endpackage

// ===== src/overwriting_trace_log_buffer_unit.sv =====
// ---------------------------------------------------------------------------
// Overwriting trace log buffer
// Circular capture buffer of storage transactions; the oldest entry is
// dropped when a record arrives at a full buffer, and pops return the oldest
// unread entry.
// ---------------------------------------------------------------------------
// Every request produces exactly one result, presented from the output
// register on the cycle after the request is accepted. A new request is taken
// every cycle unless the held result is stalled; the single entry memory
// (4096 x 80 bits, one write and one read port) is written by a record and
// read by a pop. Entries are not cleared after reset and none is needed:
// pops only read slots that were written. Logging is enabled out of reset;
// change it only while no result is pending.
`include "overwriting_trace_log_buffer_unit_macros.svh"

module overwriting_trace_log_buffer_unit import otlb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  input  logic [7:0]            kind_code_i,
  input  logic [31:0]           block_address_i,
  input  logic [31:0]           block_count_i,
  input  logic [31:0]           time_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  accepted_o,
  output logic                  entry_valid_o,
  output logic [TimeW-1:0]      entry_time_o,
  output logic                  entry_is_write_o,
  output logic [BlockW-1:0]     entry_block_o,
  output logic [CountW-1:0]     entry_count_o,
  output logic [UnreadOutW-1:0] unread_count_o,
  output logic                  has_wrapped_o
);

  logic              logging_q;
  logic [PtrW-1:0]   wp_q, wp_d;
  logic [PtrW-1:0]   rp_q, rp_d;
  logic [CntW-1:0]   unread_q, unread_d;
  logic              wrapped_q, wrapped_d;
  logic              out_valid_q, out_valid_d;
  logic              accepted_q, entry_valid_q;

  logic              req_acc;
  logic              rec_ok;
  logic              pop_ok;
  logic              full;
  logic [PtrW-1:0]   wp_inc, rp_inc;
  logic [EntryW-1:0] wr_data;
  logic [EntryW-1:0] rd_data_q;
  logic [EntryW-1:0] trace_mem [EntryDepth];

  assign in_stall_o = out_valid_q & out_stall_i;
  assign req_acc    = in_valid_i & ~in_stall_o;

  assign rec_ok = req_acc && (op_i == OpRecord) && logging_q && (kind_code_i <= KindWrite);
  assign pop_ok = req_acc && (op_i == OpPop) && (unread_q != '0);
  assign full   = (unread_q == FullCount);
  assign wp_inc = (wp_q == LastSlot) ? '0 : wp_q + 1'b1;
  assign rp_inc = (rp_q == LastSlot) ? '0 : rp_q + 1'b1;

  assign wr_data = {kind_code_i[0], block_address_i[BlockW-1:0],
                    block_count_i[CountW-1:0], time_ms_i};

  always_comb begin
    wp_d        = wp_q;
    rp_d        = rp_q;
    unread_d    = unread_q;
    wrapped_d   = wrapped_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (req_acc) begin
      out_valid_d = 1'b1;
    end
    if (rec_ok) begin
      wp_d = wp_inc;
      if (wp_inc == '0) begin
        wrapped_d = 1'b1;
      end
      if (full) begin
        rp_d = rp_inc;
      end else begin
        unread_d = unread_q + 1'b1;
      end
    end else if (pop_ok) begin
      rp_d     = rp_inc;
      unread_d = unread_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      logging_q     <= 1'b1;
      wp_q          <= '0;
      rp_q          <= '0;
      unread_q      <= '0;
      wrapped_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      accepted_q    <= 1'b0;
      entry_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        logging_q <= cfg_wdata_i;
      end
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      unread_q    <= unread_d;
      wrapped_q   <= wrapped_d;
      out_valid_q <= out_valid_d;
      if (req_acc) begin
        accepted_q    <= rec_ok;
        entry_valid_q <= pop_ok;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_ok) begin
      trace_mem[wp_q] <= wr_data;
    end
    if (pop_ok) begin
      rd_data_q <= trace_mem[rp_q];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = accepted_q;
  assign entry_valid_o    = entry_valid_q;
  assign entry_is_write_o = entry_valid_q & rd_data_q[EntryW-1];
  assign entry_block_o    = entry_valid_q ? rd_data_q[EntryW-2 -: BlockW] : '0;
  assign entry_count_o    = entry_valid_q ? rd_data_q[TimeW+CountW-1 -: CountW] : '0;
  assign entry_time_o     = entry_valid_q ? rd_data_q[TimeW-1:0] : '0;
  assign unread_count_o   = UnreadOutW'(unread_q);
  assign has_wrapped_o    = wrapped_q;

  `OTLB_ASSERT(a_unread_bound, unread_q <= FullCount)
  `OTLB_ASSERT(a_result_follows, req_acc |=> out_valid_q)
  `OTLB_ASSERT(a_pop_valid_match, (req_acc && op_i == OpPop) |=> (entry_valid_q == ($past(unread_q) != '0)))
  `OTLB_ASSERT(a_full_stays_full, (rec_ok && full) |=> (unread_q == FullCount && rp_q == wp_q))
  `OTLB_ASSERT(a_one_outcome, !(accepted_q && entry_valid_q))

endmodule

// ===== test/tb_overwriting_trace_log_buffer_unit.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Trace log buffer testbench
// Drives record and pop requests with random gaps and output stalls, predicts
// every reply with a behavioral copy of the circular buffer and checks each
// reply field by field. Covers refused kinds, logging off, empty pops and a
// complete drain past empty.
// ---------------------------------------------------------------------------
module tb_overwriting_trace_log_buffer_unit;
  import otlb_pkg::*;

  localparam int unsigned StallLimit = 3000;

  typedef struct packed {
    logic        op;
    logic [7:0]  kind;
    logic [31:0] block;
    logic [31:0] count;
    logic [31:0] stamp;
  } request_t;

  typedef struct packed {
    logic                  accepted;
    logic                  entry_valid;
    logic [TimeW-1:0]      entry_time;
    logic                  is_write;
    logic [BlockW-1:0]     block;
    logic [CountW-1:0]     count;
    logic [UnreadOutW-1:0] unread;
    logic                  wrapped;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        op_i = OpRecord;
  logic [7:0]  kind_code_i = KindRead;
  logic [31:0] block_address_i = '0;
  logic [31:0] block_count_i = '0;
  logic [31:0] time_ms_i = '0;
  logic        out_stall_i = 1'b0;

  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  accepted_o;
  logic                  entry_valid_o;
  logic [TimeW-1:0]      entry_time_o;
  logic                  entry_is_write_o;
  logic [BlockW-1:0]     entry_block_o;
  logic [CountW-1:0]     entry_count_o;
  logic [UnreadOutW-1:0] unread_count_o;
  logic                  has_wrapped_o;

  overwriting_trace_log_buffer_unit dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .op_i,
    .kind_code_i,
    .block_address_i,
    .block_count_i,
    .time_ms_i,
    .out_valid_o,
    .out_stall_i,
    .accepted_o,
    .entry_valid_o,
    .entry_time_o,
    .entry_is_write_o,
    .entry_block_o,
    .entry_count_o,
    .unread_count_o,
    .has_wrapped_o
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the buffer
  logic [31:0]       stamp_mem [EntryDepth];
  logic [47:0]       txn_mem [EntryDepth];
  logic [PtrW-1:0]   wr_ptr = '0;
  logic [PtrW-1:0]   rd_ptr = '0;
  logic [CntW-1:0]   fill = '0;
  logic              wrapped = 1'b0;
  logic              log_enable = 1'b1;

  request_t request_q[$];
  reply_t   log_replies_q[$];
  int       fail_cnt = 0;

  function automatic reply_t log_buffer_step(request_t rq);
    reply_t rp;
    logic [47:0] txn;
    rp = '0;
    if (rq.op == OpRecord) begin
      if (log_enable && rq.kind <= KindWrite) begin
        stamp_mem[wr_ptr] = rq.stamp;
        txn_mem[wr_ptr] = {rq.kind[0], rq.block[BlockW-1:0], rq.count[CountW-1:0]};
        wr_ptr = wr_ptr + 1'b1;
        if (wr_ptr == '0) wrapped = 1'b1;
        if (fill == FullCount) rd_ptr = rd_ptr + 1'b1;
        else fill = fill + 1'b1;
        rp.accepted = 1'b1;
      end
    end else if (fill != '0) begin
      txn = txn_mem[rd_ptr];
      rp.entry_valid = 1'b1;
      rp.entry_time = stamp_mem[rd_ptr];
      rp.is_write = txn[47];
      rp.block = txn[46:16];
      rp.count = txn[15:0];
      rd_ptr = rd_ptr + 1'b1;
      fill = fill - 1'b1;
    end
    rp.unread = fill[UnreadOutW-1:0];
    rp.wrapped = wrapped;
    return rp;
  endfunction

  // mostly short gaps, a few long ones, and occasional runs with none
  function automatic int unsigned pick_gap(inout int unsigned streak);
    int unsigned r;
    if (streak > 0) begin
      streak--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      streak = $urandom_range(20, 100);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic request_t record_req(logic [7:0] k, logic [31:0] b, logic [31:0] c,
                                          logic [31:0] s);
    request_t rq;
    rq.op = OpRecord;
    rq.kind = k;
    rq.block = b;
    rq.count = c;
    rq.stamp = s;
    return rq;
  endfunction

  function automatic request_t pop_req();
    request_t rq;
    rq.op = OpPop;
    rq.kind = 8'($urandom_range(0, 255));
    rq.block = $urandom();
    rq.count = $urandom();
    rq.stamp = $urandom();
    return rq;
  endfunction

  function automatic request_t random_record(int unsigned bad_pct);
    logic [7:0] k;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < bad_pct) k = 8'($urandom_range(0, 255));
    else k = r[0] ? KindWrite : KindRead;
    return record_req(k, pick_word(), pick_word(), pick_word());
  endfunction

  // driver
  request_t    cur_rq;
  int unsigned send_gap = 0;
  int unsigned send_streak = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) log_replies_q.push_back(log_buffer_step(cur_rq));
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (request_q.size() > 0) begin
          cur_rq = request_q.pop_front();
          op_i <= cur_rq.op;
          kind_code_i <= cur_rq.kind;
          block_address_i <= cur_rq.block;
          block_count_i <= cur_rq.count;
          time_ms_i <= cur_rq.stamp;
          in_valid_i <= 1'b1;
          send_gap = pick_gap(send_streak);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // monitor and output stall
  int unsigned stall_left = 0;
  int unsigned stall_streak = 0;
  reply_t      want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (log_replies_q.size() == 0) begin
          $error("reply with no request outstanding");
          fail_cnt++;
        end else begin
          want = log_replies_q.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(accepted_o));
          check_field("entry_valid", 32'(want.entry_valid), 32'(entry_valid_o));
          check_field("entry_time", want.entry_time, entry_time_o);
          check_field("entry_is_write", 32'(want.is_write), 32'(entry_is_write_o));
          check_field("entry_block", 32'(want.block), 32'(entry_block_o));
          check_field("entry_count", 32'(want.count), 32'(entry_count_o));
          check_field("unread_count", 32'(want.unread), 32'(unread_count_o));
          check_field("has_wrapped", 32'(want.wrapped), 32'(has_wrapped_o));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = pick_gap(stall_streak);
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // sampled at the falling edge, after every rising-edge update has settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (request_q.size() != 0 || in_valid_i || out_valid_o || log_replies_q.size() != 0);
  endtask

  task automatic set_logging(logic en);
    wait_drained();
    repeat (3) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    log_enable = en;
  endtask

  initial begin
    int unsigned r;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    request_q.push_back(pop_req());
    request_q.push_back(record_req(KindRead, '1, '1, '1));
    request_q.push_back(record_req(KindWrite, '0, '0, '0));
    request_q.push_back(record_req(8'd2, $urandom(), $urandom(), $urandom()));
    request_q.push_back(record_req(8'hFF, '1, '1, '1));
    request_q.push_back(record_req(KindWrite, 32'h8000_0000, 32'h0001_0000, 32'h8000_0000));
    request_q.push_back(record_req(KindRead, 32'h7FFF_FFFF, 32'h0000_FFFF, 32'h7FFF_FFFF));
    repeat (5) request_q.push_back(pop_req());
    request_q.push_back(record_req(KindWrite, 32'h1234_5678, 32'h0000_0010, 32'd1000));
    set_logging(1'b0);
    request_q.push_back(record_req(KindRead, $urandom(), $urandom(), $urandom()));
    request_q.push_back(record_req(KindWrite, $urandom(), $urandom(), $urandom()));
    request_q.push_back(record_req(8'h80, '1, '1, '1));
    request_q.push_back(pop_req());
    request_q.push_back(pop_req());
    set_logging(1'b0);
    set_logging(1'b1);
    request_q.push_back(record_req(KindRead, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
    request_q.push_back(pop_req());

    // random mix
    for (int i = 0; i < 300; i++) begin
      if (i == 120) wait_drained();
      if (i == 200) set_logging(1'b0);
      if (i == 230) set_logging(1'b1);
      r = $urandom_range(0, 99);
      if (r < 60) request_q.push_back(random_record(15));
      else request_q.push_back(pop_req());
    end
    wait_drained();

    // drain past empty
    for (int i = 0; i < int'(fill) + 5; i++) request_q.push_back(pop_req());

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
